// ===== src/ppm_pkg.sv =====
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared widths, payload types and controller/datapath command types for the
// polyline proximity monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package ppm_pkg;

  localparam int CoordW    = 20;
  localparam int DiffW     = CoordW + 1;
  localparam int MulW      = DiffW + 1;
  localparam int ProdW     = 2 * MulW;
  localparam int HalfW     = DiffW;
  localparam int NumW      = 2 * HalfW;
  localparam int SqW       = 2 * NumW;
  localparam int DistW     = 44;
  localparam int CountW    = 16;
  localparam int CountOutW = 16;
  localparam int CntW      = $clog2(NumW + 1);
  localparam int StepW     = 4;

  // Product schedule of the shared multiplier.
  localparam logic [StepW-1:0] StepDot   = StepW'(3);
  localparam logic [StepW-1:0] StepWa    = StepW'(6);
  localparam logic [StepW-1:0] StepWb    = StepW'(9);
  localparam logic [StepW-1:0] StepSqLo  = StepW'(12);
  localparam logic [StepW-1:0] StepSqMid = StepW'(13);
  localparam logic [StepW-1:0] StepSqHi  = StepW'(14);
  localparam logic [StepW-1:0] StepCount = StepW'(15);

  localparam logic [DistW-1:0] CollisionReset = DistW'(500000);
  localparam logic [DistW-1:0] WarningReset   = DistW'(1000000);

  typedef struct packed {
    logic signed [CoordW-1:0] link_x;
    logic signed [CoordW-1:0] link_y;
    logic signed [CoordW-1:0] link_z;
    logic signed [CoordW-1:0] person_x;
    logic signed [CoordW-1:0] person_y;
    logic signed [CoordW-1:0] person_z;
    logic                     arm_moving;
    logic                     chain_end;
  } in_pl_t;

  typedef struct packed {
    logic [DistW-1:0]     min_distance_sq;
    logic                 collision_event;
    logic                 warning_event;
    logic [CountOutW-1:0] collision_total;
    logic [CountOutW-1:0] warning_total;
  } out_pl_t;

  typedef struct packed {
    logic             load;
    logic             mul_en;
    logic [StepW-1:0] mul_idx;
    logic             acc_en;
    logic [StepW-1:0] acc_idx;
    logic             div_init;
    logic             div_step;
    logic             commit;
    logic             finish;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic chain_end;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/ppm_in_if.sv =====
// ----------------------------------------------------------------------------
// ppm_in_if
// Valid/ready channel carrying one chain point per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppm_in_if;
  logic            valid;
  logic            ready;
  ppm_pkg::in_pl_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/ppm_out_if.sv =====
// ----------------------------------------------------------------------------
// ppm_out_if
// Valid/ready channel carrying one chain report per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppm_out_if;
  logic             valid;
  logic             ready;
  ppm_pkg::out_pl_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/ppm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppm_ctrl
// Sequencer: product schedule, serial divide, commit and report hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire ppm_pkg::sts_t sts_i,
  output ppm_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StDiv,
    StCommit,
    StFin
  } state_e;

  state_e                       state_q;
  logic [ppm_pkg::CntW-1:0]     cnt_q;
  logic                         out_valid_q;
  logic [ppm_pkg::CntW-1:0]     cnt_m1;

  assign cnt_m1      = cnt_q - ppm_pkg::CntW'(1);
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == StIdle) && in_valid_i;
    cmd_o.mul_idx  = cnt_q[ppm_pkg::StepW-1:0];
    cmd_o.acc_idx  = cnt_m1[ppm_pkg::StepW-1:0];
    cmd_o.mul_en   = (state_q == StMul) &&
                     (cnt_q < ppm_pkg::CntW'(ppm_pkg::StepCount));
    cmd_o.acc_en   = (state_q == StMul) && (cnt_q != '0);
    cmd_o.div_init = (state_q == StDiv) && (cnt_q == '0);
    cmd_o.div_step = (state_q == StDiv) && (cnt_q != '0);
    cmd_o.commit   = (state_q == StCommit);
    cmd_o.finish   = (state_q == StFin) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          cnt_q <= '0;
          if (in_valid_i) begin
            state_q <= StMul;
          end
        end
        StMul: begin
          if (cnt_q == ppm_pkg::CntW'(ppm_pkg::StepCount)) begin
            cnt_q   <= '0;
            state_q <= sts_i.in_range ? StDiv : StCommit;
          end else begin
            cnt_q <= cnt_q + ppm_pkg::CntW'(1);
          end
        end
        StDiv: begin
          if (cnt_q == ppm_pkg::CntW'(ppm_pkg::NumW)) begin
            cnt_q   <= '0;
            state_q <= StCommit;
          end else begin
            cnt_q <= cnt_q + ppm_pkg::CntW'(1);
          end
        end
        StCommit: begin
          state_q <= sts_i.chain_end ? StFin : StIdle;
        end
        StFin: begin
          if (cmd_o.finish) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // A report never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_valid_q || out_ready_i))
    else $error("report overwritten");

  a_div_only_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMul && cnt_q == ppm_pkg::CntW'(ppm_pkg::StepCount) && !sts_i.in_range)
    |=> state_q == StCommit)
    else $error("divide entered out of range");

  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o)
    else $error("item accepted while busy");

endmodule

`default_nettype wire

// ===== src/ppm_dp.sv =====
// ----------------------------------------------------------------------------
// ppm_dp
// Datapath: difference registers, shared multiplier with accumulators, serial
// restoring divider, running minimum, event logic and report register.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ppm_pkg::cmd_t                cmd_i,
  input  wire ppm_pkg::in_pl_t              in_pl_i,
  input  wire logic [ppm_pkg::DistW-1:0]    coll_limit_i,
  input  wire logic [ppm_pkg::DistW-1:0]    warn_limit_i,
  output ppm_pkg::sts_t                     sts_o,
  output ppm_pkg::out_pl_t                  out_pl_o
);

  localparam int DiffW = ppm_pkg::DiffW;
  localparam int MulW  = ppm_pkg::MulW;
  localparam int ProdW = ppm_pkg::ProdW;
  localparam int HalfW = ppm_pkg::HalfW;
  localparam int NumW  = ppm_pkg::NumW;
  localparam int SqW   = ppm_pkg::SqW;
  localparam int DistW = ppm_pkg::DistW;

  logic signed [ppm_pkg::CoordW-1:0] cur    [3];
  logic signed [ppm_pkg::CoordW-1:0] per    [3];
  logic signed [ppm_pkg::CoordW-1:0] prior_q[3];
  logic signed [DiffW-1:0]           d_q[3];
  logic signed [DiffW-1:0]           w_q[3];
  logic signed [DiffW-1:0]           v_q[3];
  logic                              have_prior_q, seg_valid_q, moving_q, end_q;
  logic signed [MulW-1:0]            op_a, op_b;
  logic signed [ProdW-1:0]           prod_q;
  logic signed [ProdW-1:0]           len_q, dot_q, wa_q, wb_q;
  logic [SqW-1:0]                    sq_q, sq_add;
  logic [NumW-1:0]                   rem_q, quo_q, len_lo, quo_ceil, wa_lo, wb_lo;
  logic [NumW:0]                     trial;
  logic                              in_range;
  logic [DistW-1:0]                  seg_dist, run_min_q, last_min_q;
  logic                              coll, warn;
  logic [ppm_pkg::CountW-1:0]        coll_cnt_q, warn_cnt_q;
  ppm_pkg::out_pl_t                  out_q;

  assign cur[0] = in_pl_i.link_x;
  assign cur[1] = in_pl_i.link_y;
  assign cur[2] = in_pl_i.link_z;
  assign per[0] = in_pl_i.person_x;
  assign per[1] = in_pl_i.person_y;
  assign per[2] = in_pl_i.person_z;

  assign len_lo   = len_q[NumW-1:0];
  assign wa_lo    = wa_q[NumW-1:0];
  assign wb_lo    = wb_q[NumW-1:0];
  assign in_range = seg_valid_q && (len_q != '0) && !dot_q[ProdW-1] && (dot_q <= len_q);
  assign sts_o.in_range  = in_range;
  assign sts_o.chain_end = end_q;
  assign out_pl_o = out_q;

  // Operand select for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.mul_idx)
      4'd0:  begin op_a = MulW'(d_q[0]); op_b = MulW'(d_q[0]); end
      4'd1:  begin op_a = MulW'(d_q[1]); op_b = MulW'(d_q[1]); end
      4'd2:  begin op_a = MulW'(d_q[2]); op_b = MulW'(d_q[2]); end
      4'd3:  begin op_a = MulW'(w_q[0]); op_b = MulW'(d_q[0]); end
      4'd4:  begin op_a = MulW'(w_q[1]); op_b = MulW'(d_q[1]); end
      4'd5:  begin op_a = MulW'(w_q[2]); op_b = MulW'(d_q[2]); end
      4'd6:  begin op_a = MulW'(w_q[0]); op_b = MulW'(w_q[0]); end
      4'd7:  begin op_a = MulW'(w_q[1]); op_b = MulW'(w_q[1]); end
      4'd8:  begin op_a = MulW'(w_q[2]); op_b = MulW'(w_q[2]); end
      4'd9:  begin op_a = MulW'(v_q[0]); op_b = MulW'(v_q[0]); end
      4'd10: begin op_a = MulW'(v_q[1]); op_b = MulW'(v_q[1]); end
      4'd11: begin op_a = MulW'(v_q[2]); op_b = MulW'(v_q[2]); end
      4'd12: begin
        op_a = signed'({1'b0, dot_q[HalfW-1:0]});
        op_b = signed'({1'b0, dot_q[HalfW-1:0]});
      end
      4'd13: begin
        op_a = signed'({1'b0, dot_q[NumW-1:HalfW]});
        op_b = signed'({1'b0, dot_q[HalfW-1:0]});
      end
      4'd14: begin
        op_a = signed'({1'b0, dot_q[NumW-1:HalfW]});
        op_b = signed'({1'b0, dot_q[NumW-1:HalfW]});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // The square of the dot product is built from three partial products.
  always_comb begin
    sq_add = SqW'(prod_q[NumW-1:0]);
    if (cmd_i.acc_idx == ppm_pkg::StepSqMid) begin
      sq_add = SqW'(prod_q[NumW-1:0]) << (HalfW + 1);
    end else if (cmd_i.acc_idx == ppm_pkg::StepSqHi) begin
      sq_add = SqW'(prod_q[NumW-1:0]) << (2 * HalfW);
    end
  end

  assign trial    = {rem_q, quo_q[NumW-1]};
  assign quo_ceil = quo_q + NumW'(rem_q != '0);

  always_comb begin
    if (in_range) begin
      seg_dist = DistW'(wa_lo - quo_ceil);
    end else begin
      seg_dist = (wa_lo < wb_lo) ? DistW'(wa_lo) : DistW'(wb_lo);
    end
  end

  assign coll = moving_q && (last_min_q > coll_limit_i) && (run_min_q < coll_limit_i);
  assign warn = !coll && moving_q && (last_min_q > warn_limit_i) &&
                (run_min_q < warn_limit_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 3; i++) begin
        d_q[i] <= DiffW'(cur[i]) - DiffW'(prior_q[i]);
        w_q[i] <= DiffW'(per[i]) - DiffW'(prior_q[i]);
        v_q[i] <= DiffW'(per[i]) - DiffW'(cur[i]);
      end
      moving_q <= in_pl_i.arm_moving;
      end_q    <= in_pl_i.chain_end;
      len_q    <= '0;
      dot_q    <= '0;
      wa_q     <= '0;
      wb_q     <= '0;
      sq_q     <= '0;
    end
    if (cmd_i.mul_en) begin
      prod_q <= op_a * op_b;
    end
    if (cmd_i.acc_en) begin
      if (cmd_i.acc_idx < ppm_pkg::StepDot) begin
        len_q <= len_q + prod_q;
      end else if (cmd_i.acc_idx < ppm_pkg::StepWa) begin
        dot_q <= dot_q + prod_q;
      end else if (cmd_i.acc_idx < ppm_pkg::StepWb) begin
        wa_q <= wa_q + prod_q;
      end else if (cmd_i.acc_idx < ppm_pkg::StepSqLo) begin
        wb_q <= wb_q + prod_q;
      end else begin
        sq_q <= sq_q + sq_add;
      end
    end
    // Restoring divide: the upper half of the numerator is already below len.
    if (cmd_i.div_init) begin
      rem_q <= sq_q[SqW-1:NumW];
      quo_q <= sq_q[NumW-1:0];
    end else if (cmd_i.div_step) begin
      if (trial >= {1'b0, len_lo}) begin
        rem_q <= NumW'(trial - {1'b0, len_lo});
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= trial[NumW-1:0];
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
    if (cmd_i.finish) begin
      out_q.min_distance_sq <= run_min_q;
      out_q.collision_event <= coll;
      out_q.warning_event   <= warn;
      out_q.collision_total <= ppm_pkg::CountOutW'(
        (coll && coll_cnt_q != '1) ? coll_cnt_q + 1'b1 : coll_cnt_q);
      out_q.warning_total   <= ppm_pkg::CountOutW'(
        (warn && warn_cnt_q != '1) ? warn_cnt_q + 1'b1 : warn_cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        prior_q[i] <= '0;
      end
      have_prior_q <= 1'b0;
      seg_valid_q  <= 1'b0;
      run_min_q    <= '1;
      last_min_q   <= '0;
      coll_cnt_q   <= '0;
      warn_cnt_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        for (int i = 0; i < 3; i++) begin
          prior_q[i] <= cur[i];
        end
        seg_valid_q  <= have_prior_q;
        have_prior_q <= !in_pl_i.chain_end;
      end
      if (cmd_i.commit && seg_valid_q && (seg_dist < run_min_q)) begin
        run_min_q <= seg_dist;
      end
      if (cmd_i.finish) begin
        last_min_q <= run_min_q;
        run_min_q  <= '1;
        if (coll && coll_cnt_q != '1) begin
          coll_cnt_q <= coll_cnt_q + 1'b1;
        end
        if (warn && warn_cnt_q != '1) begin
          warn_cnt_q <= warn_cnt_q + 1'b1;
        end
      end
    end
  end

  a_rem_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_step && in_range) |=> rem_q < len_lo)
    else $error("divider remainder out of range");

  a_dist_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && in_range) |-> seg_dist <= DistW'(wa_lo))
    else $error("in-range distance above endpoint distance");

  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> !(out_q.collision_event && out_q.warning_event))
    else $error("both events flagged");

endmodule

`default_nettype wire

// ===== src/polyline_proximity_monitor_core.sv =====
// ----------------------------------------------------------------------------
// polyline_proximity_monitor_core
// Squared distance from a person to an arm's point chain, with events.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake       Beat
// in_bus    in   valid/ready     one chain point with person and flags
// out_bus   out  valid/ready     one report per chain end
// apb       in   psel/penable    limit registers at 0x0 and 0x8
//
// A point runs the product schedule, then the serial divider when it has a segment
// that is in range (one quotient bit per cycle, 42 bits), then a commit step.
// A chain end adds a finish step that hands the report to the output register.
// Reset clears all control state and loads the limits' reset values.
// A stalled output holds its report; points are still taken until the next
// chain end, which then waits until the held report leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_proximity_monitor_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ppm_in_if.sink           in_bus,
  ppm_out_if.source        out_bus,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  logic [ppm_pkg::DistW-1:0] coll_limit_q, warn_limit_q;
  ppm_pkg::cmd_t             cmd;
  ppm_pkg::sts_t             sts;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = paddr[3] ? 64'(warn_limit_q) : 64'(coll_limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coll_limit_q <= ppm_pkg::CollisionReset;
      warn_limit_q <= ppm_pkg::WarningReset;
    end else if (wr_en) begin
      if (paddr[3]) begin
        warn_limit_q <= pwdata[ppm_pkg::DistW-1:0];
      end else begin
        coll_limit_q <= pwdata[ppm_pkg::DistW-1:0];
      end
    end
  end

  ppm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_bus.valid),
    .in_ready_o  (in_bus.ready),
    .out_valid_o (out_bus.valid),
    .out_ready_i (out_bus.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ppm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_pl_i      (in_bus.payload),
    .coll_limit_i (coll_limit_q),
    .warn_limit_i (warn_limit_q),
    .sts_o        (sts),
    .out_pl_o     (out_bus.payload)
  );

endmodule

`default_nettype wire
